// ----- rtl/lwrr_pkg.sv -----
// Shared widths, codes and control/status bundles of the leased worker round-robin block.
package lwrr_pkg;

   // default table depth
   localparam int MAX_SLOTS_DEF = 16;

   // field widths
   localparam int CMD_W      = 2;
   localparam int IP_W       = 32;
   localparam int PORT_W     = 16;
   localparam int OFFER_W    = 16;
   localparam int HANDLE_W   = 4;
   localparam int TIME_W     = 32;
   localparam int EXP_W      = TIME_W + 1;
   localparam int ST_W       = 2;
   localparam int MAXW_W     = 5;
   localparam int SVC_W      = 16;
   localparam int NUM_HANDLES = 1 << HANDLE_W;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WORKERS  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVICE_TIME = 1'd1;
   localparam logic [MAXW_W-1:0]    MAXW_RESET       = 5'd10;
   localparam logic [SVC_W-1:0]     SVC_RESET        = 16'd10;

   // command codes
   localparam logic [CMD_W-1:0] CMD_REGISTER   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UNREGISTER = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REDIRECT   = 2'd2;

   // status codes
   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_BAD_PORT  = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
   localparam logic [ST_W-1:0] ST_NO_HANDLE = 2'd3;

   // one table entry
   typedef struct packed {
      logic [IP_W-1:0]     ip;
      logic [PORT_W-1:0]   port;
      logic [EXP_W-1:0]    expiry;
      logic [HANDLE_W-1:0] handle;
   } lwrr_entry_type;

   // controller to datapath
   typedef struct packed {
      logic            idle;
      logic            do_register;
      logic            idx_clear;
      logic            idx_inc;
      logic            rd_en;
      logic            rd_next;
      logic            rd_pos;
      logic            shift_write;
      logic            drop_begin;
      logic            drop_fix;
      logic            rsp_load;
      logic [ST_W-1:0] status;
   } lwrr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic             req_valid;
      logic [CMD_W-1:0] command;
      logic             port_zero;
      logic             table_full;
      logic             handle_used;
      logic             scan_end;
      logic             scan_hit;
      logic             shift_done;
      logic             pointed;
      logic             expired;
      logic             out_free;
   } lwrr_stat_type;

endpackage

// ----- rtl/lwrr_req_if.sv -----
// Request channel: valid/ready handshake carrying one command word.
interface lwrr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] client_ip;
   logic [15:0] client_port;
   logic [15:0] offer_seconds;
   logic [3:0]  handle_in;
   logic [31:0] now_seconds;

   modport source (
      output valid, command, client_ip, client_port, offer_seconds, handle_in, now_seconds,
      input  ready
   );
   modport sink (
      input  valid, command, client_ip, client_port, offer_seconds, handle_in, now_seconds,
      output ready
   );
endinterface

// ----- rtl/lwrr_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one result word.
interface lwrr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [3:0]  handle_out;
   logic        serve_self;
   logic [31:0] worker_ip;
   logic [15:0] worker_port;
   logic        help_wanted;
   logic [15:0] help_time;

   modport source (
      output valid, status, handle_out, serve_self, worker_ip, worker_port, help_wanted,
             help_time,
      input  ready
   );
   modport sink (
      input  valid, status, handle_out, serve_self, worker_ip, worker_port, help_wanted,
             help_time,
      output ready
   );
endinterface

// ----- rtl/leased_worker_round_robin.sv -----
// Leased worker round-robin table: top level joining controller and datapath.
//
// Channels: req_chan carries one command word (register, unregister, redirect),
// rsp_chan returns exactly one result word per accepted command, both with a
// valid/ready handshake. csr_* writes max_workers (index 0) and service_time
// (index 1); the user must write them only while the block is idle, which the
// block itself does not enforce. Register, a rejected unregister and the
// unused command go straight to the result. Unregister reads and compares
// entries up to the match, then moves each later entry down one slot.
// Redirect reads the pointed worker, if any; while it has expired it is
// dropped, later entries are moved down and the new pointed worker is read.
// Each move reads an entry from the table memory and writes it one slot lower.
// A new word can be accepted in the cycle after the previous result is loaded.
// One command is processed at a time; the next word is taken as soon as the
// previous result sits in the response register, even if it is not yet taken.
// When the receiver stalls, the result holds and a finished command waits
// for the register to free up. Reset empties the table, frees all handles,
// invalidates the pointer and sets both registers to 10.
module leased_worker_round_robin
   import lwrr_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   lwrr_req_if.sink              req_chan,
   lwrr_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   lwrr_cmd_type  cmd;
   lwrr_stat_type stat;

   // sequencing
   lwrr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   // table and response path
   lwrr_dp #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

// ----- rtl/lwrr_ctrl.sv -----
// Sequencing state machine: dispatches commands, scans, compacts and expires entries.
module lwrr_ctrl
   import lwrr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  lwrr_stat_type stat,
   output lwrr_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DISPATCH  = 4'd1;
   localparam logic [3:0] S_FIND_RD   = 4'd2;
   localparam logic [3:0] S_FIND_CMP  = 4'd3;
   localparam logic [3:0] S_SHIFT_RD  = 4'd4;
   localparam logic [3:0] S_SHIFT_WR  = 4'd5;
   localparam logic [3:0] S_DROP_FIX  = 4'd6;
   localparam logic [3:0] S_EXP_RD    = 4'd7;
   localparam logic [3:0] S_EXP_CMP   = 4'd8;
   localparam logic [3:0] S_FINISH    = 4'd9;

   logic [3:0]      state_ff, state_in;
   logic [ST_W-1:0] status_ff, status_in;

   // next state and datapath commands
   always_comb begin
      cmd        = '0;
      cmd.status = status_ff;
      state_in   = state_ff;
      status_in  = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.idle = 1'b1;
            if (stat.req_valid) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            status_in = ST_OK;
            state_in  = S_FINISH;
            unique case (stat.command)
               CMD_REGISTER: begin
                  if (stat.port_zero) begin
                     status_in = ST_BAD_PORT;
                  end else if (stat.table_full) begin
                     status_in = ST_FULL;
                  end else begin
                     cmd.do_register = 1'b1;
                  end
               end
               CMD_UNREGISTER: begin
                  if (!stat.handle_used) begin
                     status_in = ST_NO_HANDLE;
                  end else begin
                     cmd.idx_clear = 1'b1;
                     state_in      = S_FIND_RD;
                  end
               end
               CMD_REDIRECT: begin
                  state_in = S_EXP_RD;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         // walk the table for the handle, one read and one compare per entry
         S_FIND_RD: begin
            if (stat.scan_end) begin
               status_in = ST_NO_HANDLE;
               state_in  = S_FINISH;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_FIND_CMP;
            end
         end
         S_FIND_CMP: begin
            if (stat.scan_hit) begin
               cmd.drop_begin = 1'b1;
               state_in       = S_SHIFT_RD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_FIND_RD;
            end
         end
         // move later entries down one slot
         S_SHIFT_RD: begin
            if (stat.shift_done) begin
               state_in = S_DROP_FIX;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_next = 1'b1;
               state_in    = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_write = 1'b1;
            state_in        = S_SHIFT_RD;
         end
         S_DROP_FIX: begin
            cmd.drop_fix = 1'b1;
            state_in     = (stat.command == CMD_REDIRECT) ? S_EXP_RD : S_FINISH;
         end
         // drop the pointed worker while its lease has run out
         S_EXP_RD: begin
            if (stat.pointed) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_pos = 1'b1;
               state_in   = S_EXP_CMP;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_EXP_CMP: begin
            if (stat.expired) begin
               cmd.drop_begin = 1'b1;
               state_in       = S_SHIFT_RD;
            end else begin
               state_in = S_FINISH;
            end
         end
         // hand the word to the response register once it has room
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

endmodule

// ----- rtl/lwrr_dp.sv -----
// Datapath: worker table memory, handle map, round-robin pointer and response register.
module lwrr_dp
   import lwrr_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   lwrr_req_if.sink              req_chan,
   lwrr_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  lwrr_cmd_type          cmd,
   output lwrr_stat_type         stat
);

   localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W = (CNT_W > MAXW_W) ? CNT_W : MAXW_W;

   // configuration
   logic [MAXW_W-1:0] max_workers_ff;
   logic [SVC_W-1:0]  service_time_ff;

   // latched request
   logic [CMD_W-1:0]    cmd_ff;
   logic [IP_W-1:0]     ip_ff;
   logic [PORT_W-1:0]   port_ff;
   logic [OFFER_W-1:0]  offer_ff;
   logic [HANDLE_W-1:0] hin_ff;
   logic [TIME_W-1:0]   now_ff;

   // table and control state
   lwrr_entry_type           mem [MAX_SLOTS];
   lwrr_entry_type           rdata_ff;
   logic [NUM_HANDLES-1:0]   in_use_ff, in_use_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rr_valid_ff, rr_valid_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         drop_idx_ff;
   logic [HANDLE_W-1:0]      hnew_ff;

   // response register
   logic                rsp_valid_ff;
   logic [ST_W-1:0]     rsp_status_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;
   logic                rsp_self_ff;
   logic [IP_W-1:0]     rsp_ip_ff;
   logic [PORT_W-1:0]   rsp_port_ff;
   logic                rsp_help_ff;
   logic [SVC_W-1:0]    rsp_help_time_ff;

   logic                take;
   logic [HANDLE_W-1:0] free_h;
   logic [CNT_W-1:0]    idx_nxt;
   logic [CNT_W-1:0]    pos_ext;
   logic [CNT_W-1:0]    pos_inc;
   logic [CNT_W-1:0]    count_dec;
   logic                pointed;
   logic                help;
   logic                is_redirect;
   logic [OFFER_W-1:0]  lease_len;
   logic [EXP_W-1:0]    lease_end;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   lwrr_entry_type      wr_data;

   assign take           = cmd.idle && req_chan.valid;
   assign req_chan.ready = cmd.idle;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_workers_ff  <= MAXW_RESET;
         service_time_ff <= SVC_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_WORKERS:  max_workers_ff  <= csr_wdata[MAXW_W-1:0];
            CSR_SERVICE_TIME: service_time_ff <= csr_wdata[SVC_W-1:0];
            default: ;
         endcase
      end
   end

   // capture the accepted word
   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff   <= req_chan.command;
         ip_ff    <= req_chan.client_ip;
         port_ff  <= req_chan.client_port;
         offer_ff <= req_chan.offer_seconds;
         hin_ff   <= req_chan.handle_in;
         now_ff   <= req_chan.now_seconds;
      end
   end

   // lowest free handle
   always_comb begin
      free_h = '0;
      for (int k = NUM_HANDLES - 1; k >= 0; k--) begin
         if (!in_use_ff[k]) begin
            free_h = HANDLE_W'(k);
         end
      end
   end

   assign idx_nxt     = idx_ff + 1'b1;
   assign pos_ext     = CNT_W'(pos_ff);
   assign pos_inc     = pos_ext + 1'b1;
   assign count_dec   = count_ff - 1'b1;
   assign pointed     = rr_valid_ff && (pos_ext < count_ff);
   assign help        = CMP_W'(count_ff) < CMP_W'(max_workers_ff);
   assign is_redirect = (cmd_ff == CMD_REDIRECT);
   assign lease_len   = (offer_ff > service_time_ff) ? service_time_ff : offer_ff;
   assign lease_end   = {1'b0, now_ff} + EXP_W'(lease_len);

   // status toward the controller
   always_comb begin
      stat.req_valid   = req_chan.valid;
      stat.command     = cmd_ff;
      stat.port_zero   = (port_ff == '0);
      stat.table_full  = (CMP_W'(count_ff) >= CMP_W'(max_workers_ff)) ||
                         (count_ff >= CNT_W'(MAX_SLOTS)) || (&in_use_ff);
      stat.handle_used = in_use_ff[hin_ff];
      stat.scan_end    = (idx_ff >= count_ff);
      stat.scan_hit    = (rdata_ff.handle == hin_ff);
      stat.shift_done  = (idx_nxt >= count_ff);
      stat.pointed     = pointed;
      stat.expired     = (rdata_ff.expiry < {1'b0, now_ff});
      stat.out_free    = !rsp_valid_ff || rsp_chan.ready;
   end

   // table port selection
   always_comb begin
      if (cmd.rd_pos) begin
         rd_addr = pos_ff;
      end else if (cmd.rd_next) begin
         rd_addr = idx_nxt[IDX_W-1:0];
      end else begin
         rd_addr = idx_ff[IDX_W-1:0];
      end
      wr_en          = cmd.do_register || cmd.shift_write;
      wr_addr        = cmd.do_register ? count_ff[IDX_W-1:0] : idx_ff[IDX_W-1:0];
      wr_data        = rdata_ff;
      if (cmd.do_register) begin
         wr_data.ip     = ip_ff;
         wr_data.port   = port_ff;
         wr_data.expiry = lease_end;
         wr_data.handle = free_h;
      end
   end

   // worker table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // next values of count, handle map, pointer and walk index
   always_comb begin
      count_in    = count_ff;
      in_use_in   = in_use_ff;
      rr_valid_in = rr_valid_ff;
      pos_in      = pos_ff;
      idx_in      = idx_ff;

      if (cmd.do_register) begin
         count_in          = count_ff + 1'b1;
         in_use_in[free_h] = 1'b1;
         if (!rr_valid_ff) begin
            rr_valid_in = 1'b1;
            pos_in      = count_ff[IDX_W-1:0];
         end
      end

      if (cmd.drop_begin) begin
         in_use_in[rdata_ff.handle] = 1'b0;
      end

      // close the gap and repair the pointer
      if (cmd.drop_fix) begin
         count_in = count_dec;
         if (rr_valid_ff) begin
            if (pos_ext == drop_idx_ff) begin
               if (drop_idx_ff >= count_dec) begin
                  rr_valid_in = 1'b0;
                  pos_in      = '0;
               end
            end else if (pos_ext > drop_idx_ff) begin
               pos_in = pos_ff - 1'b1;
            end
         end
      end

      // advance round robin after a served redirect
      if (cmd.rsp_load && is_redirect && pointed) begin
         pos_in = (pos_inc >= count_ff) ? '0 : pos_inc[IDX_W-1:0];
      end

      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.rd_pos) begin
         idx_in = pos_ext;
      end else if (cmd.idx_inc || cmd.shift_write) begin
         idx_in = idx_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         in_use_ff   <= '0;
         rr_valid_ff <= 1'b0;
         pos_ff      <= '0;
      end else begin
         count_ff    <= count_in;
         in_use_ff   <= in_use_in;
         rr_valid_ff <= rr_valid_in;
         pos_ff      <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.drop_begin) begin
         drop_idx_ff <= idx_ff;
      end
      if (cmd.do_register) begin
         hnew_ff <= free_h;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff    <= cmd.status;
         rsp_handle_ff    <= (cmd_ff == CMD_REGISTER && cmd.status == ST_OK) ? hnew_ff : '0;
         rsp_self_ff      <= is_redirect && !pointed;
         rsp_ip_ff        <= (is_redirect && pointed) ? rdata_ff.ip : '0;
         rsp_port_ff      <= (is_redirect && pointed) ? rdata_ff.port : '0;
         rsp_help_ff      <= is_redirect && help;
         rsp_help_time_ff <= (is_redirect && help) ? service_time_ff : '0;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.handle_out  = rsp_handle_ff;
   assign rsp_chan.serve_self  = rsp_self_ff;
   assign rsp_chan.worker_ip   = rsp_ip_ff;
   assign rsp_chan.worker_port = rsp_port_ff;
   assign rsp_chan.help_wanted = rsp_help_ff;
   assign rsp_chan.help_time   = rsp_help_time_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SLOTS))
      else $error("worker count beyond table depth");

   a_pointer_in_table: assert property (@(posedge clock) disable iff (reset)
      rr_valid_ff |-> (pos_ext < count_ff))
      else $error("round-robin pointer past last worker");

   a_pointer_parked: assert property (@(posedge clock) disable iff (reset)
      !rr_valid_ff |-> (pos_ff == '0))
      else $error("invalid pointer not parked at zero");

   a_handles_match_count: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> ($countones(in_use_ff) == int'(count_ff)))
      else $error("handle map out of step with worker count");

   a_empty_no_pointer: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && count_ff == '0) |-> !rr_valid_ff)
      else $error("pointer valid on empty table");
`endif

endmodule
